// File: src/bstf_pkg.sv
// Shared types and constants for the byte-stuffing transmit framer.
// No dependencies; used by byte_stuffing_tx_framer_core.
`default_nettype none

package bstf_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] kind_t;
    typedef logic [1:0] cfg_index_t;
    typedef logic [1:0] run_count_t;

    localparam kind_t KIND_START = 2'd0;
    localparam kind_t KIND_DATA  = 2'd1;
    localparam kind_t KIND_STOP  = 2'd2;

    localparam cfg_index_t CFG_START_TOKEN = 2'd0;
    localparam cfg_index_t CFG_STOP_TOKEN  = 2'd1;
    localparam cfg_index_t CFG_SKIP_TOKEN  = 2'd2;
    localparam cfg_index_t CFG_NOP_BYTE    = 2'd3;

    localparam byte_t START_TOKEN_RESET = 8'd170;
    localparam byte_t STOP_TOKEN_RESET  = 8'd85;
    localparam byte_t SKIP_TOKEN_RESET  = 8'd90;
    localparam byte_t NOP_BYTE_RESET    = 8'd0;

    localparam run_count_t RUN_EMPTY = 2'd0;
    localparam run_count_t RUN_ONE   = 2'd1;
    localparam run_count_t RUN_TWO   = 2'd2;
    localparam run_count_t RUN_THREE = 2'd3;

endpackage

`default_nettype wire

// File: src/byte_stuffing_tx_framer_core.sv
// Byte-stuffing transmit framer: command beats in, framed line bytes out.
// Depends on bstf_pkg for types, command codes and register indexes.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per beat: start,
//   data byte or stop. Output channel (out_valid/out_ready) carries one line
//   byte per beat; run_end marks the last byte belonging to a command.
//   Start gives two bytes, stop gives three, a data byte gives one or two
//   (two when it must be escaped). Command code 3 is taken and dropped.
//   The first byte of a command passes through the run register and then
//   the output register before it is offered. Throughput: one line byte per
//   cycle while the receiver is ready; a command is taken in the same cycle
//   as the last byte of the previous command moves to the output register,
//   so plain data bytes stream at one per cycle. The three-entry run register
//   feeding the single output register sets this figure. Token registers are
//   written through cfg_write/cfg_index/cfg_data while the framer is idle;
//   the user must keep to this, as the block does not enforce it. Reset
//   restores the default tokens, clears the remembered data byte and empties
//   both stages. When the receiver stalls, the output byte holds and the run
//   register fills; the input is then held off until the run drains.
`default_nettype none

module byte_stuffing_tx_framer_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bstf_pkg::kind_t     kind,
    input  wire bstf_pkg::byte_t     data_byte,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output bstf_pkg::byte_t          line_byte,
    output logic                     run_end,
    input  wire logic                cfg_write,
    input  wire bstf_pkg::cfg_index_t cfg_index,
    input  wire bstf_pkg::byte_t     cfg_data
);

    bstf_pkg::byte_t      start_token_reg;
    bstf_pkg::byte_t      stop_token_reg;
    bstf_pkg::byte_t      skip_token_reg;
    bstf_pkg::byte_t      nop_byte_reg;
    bstf_pkg::byte_t      prev_data_reg;
    bstf_pkg::byte_t      prev_data_next;

    bstf_pkg::byte_t      run0_reg, run1_reg, run2_reg;
    bstf_pkg::byte_t      run0_next, run1_next, run2_next;
    bstf_pkg::run_count_t run_left_reg, run_left_next;

    logic                 out_valid_reg, out_valid_next;
    bstf_pkg::byte_t      line_byte_reg, line_byte_next;
    logic                 run_end_reg, run_end_next;

    logic                 in_take;
    logic                 out_load;
    logic                 escape;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_token_reg <= bstf_pkg::START_TOKEN_RESET;
            stop_token_reg  <= bstf_pkg::STOP_TOKEN_RESET;
            skip_token_reg  <= bstf_pkg::SKIP_TOKEN_RESET;
            nop_byte_reg    <= bstf_pkg::NOP_BYTE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bstf_pkg::CFG_START_TOKEN: start_token_reg <= cfg_data;
                bstf_pkg::CFG_STOP_TOKEN:  stop_token_reg  <= cfg_data;
                bstf_pkg::CFG_SKIP_TOKEN:  skip_token_reg  <= cfg_data;
                bstf_pkg::CFG_NOP_BYTE:    nop_byte_reg    <= cfg_data;
                default:                   nop_byte_reg    <= nop_byte_reg;
            endcase
        end
    end

    assign out_load = (run_left_reg != bstf_pkg::RUN_EMPTY) && (!out_valid_reg || out_ready);
    assign in_ready = (run_left_reg == bstf_pkg::RUN_EMPTY)
                   || ((run_left_reg == bstf_pkg::RUN_ONE) && out_load);
    assign in_take  = in_valid && in_ready;
    assign escape   = (data_byte == skip_token_reg)
                   || ((prev_data_reg == stop_token_reg) && (data_byte == stop_token_reg));

    always_comb
    begin
        run0_next      = run0_reg;
        run1_next      = run1_reg;
        run2_next      = run2_reg;
        run_left_next  = run_left_reg;
        prev_data_next = prev_data_reg;

        if (out_load)
        begin
            run0_next     = run1_reg;
            run1_next     = run2_reg;
            run_left_next = run_left_reg - bstf_pkg::RUN_ONE;
        end

        if (in_take)
        begin
            unique case (kind)
                bstf_pkg::KIND_START:
                begin
                    run0_next      = start_token_reg;
                    run1_next      = start_token_reg;
                    run_left_next  = bstf_pkg::RUN_TWO;
                    prev_data_next = '0;
                end
                bstf_pkg::KIND_DATA:
                begin
                    prev_data_next = data_byte;
                    if (escape)
                    begin
                        run0_next     = skip_token_reg;
                        run1_next     = data_byte;
                        run_left_next = bstf_pkg::RUN_TWO;
                    end
                    else
                    begin
                        run0_next     = data_byte;
                        run_left_next = bstf_pkg::RUN_ONE;
                    end
                end
                bstf_pkg::KIND_STOP:
                begin
                    run0_next     = nop_byte_reg;
                    run1_next     = stop_token_reg;
                    run2_next     = stop_token_reg;
                    run_left_next = bstf_pkg::RUN_THREE;
                end
                default:
                begin
                    run_left_next = bstf_pkg::RUN_EMPTY;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        line_byte_next = line_byte_reg;
        run_end_next   = run_end_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            line_byte_next = run0_reg;
            run_end_next   = (run_left_reg == bstf_pkg::RUN_ONE);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_left_reg  <= bstf_pkg::RUN_EMPTY;
            out_valid_reg <= 1'b0;
            prev_data_reg <= '0;
        end
        else
        begin
            run_left_reg  <= run_left_next;
            out_valid_reg <= out_valid_next;
            prev_data_reg <= prev_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run0_reg      <= run0_next;
        run1_reg      <= run1_next;
        run2_reg      <= run2_next;
        line_byte_reg <= line_byte_next;
        run_end_reg   <= run_end_next;
    end

    assign out_valid = out_valid_reg;
    assign line_byte = line_byte_reg;
    assign run_end   = run_end_reg;

    // A byte that does not close its command must leave the rest of the run queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !run_end_reg) |-> (run_left_reg != bstf_pkg::RUN_EMPTY))
        else $error("open run has no queued bytes");

    assert property (@(posedge clk) disable iff (!rst_n)
        (run_left_reg == bstf_pkg::RUN_EMPTY) |-> in_ready)
        else $error("input held off with an empty run");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (kind == bstf_pkg::KIND_DATA)) |=> (prev_data_reg == $past(data_byte)))
        else $error("data byte not remembered");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (kind == bstf_pkg::KIND_STOP)) |=> (run_left_reg == bstf_pkg::RUN_THREE))
        else $error("stop command did not queue three bytes");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (kind == bstf_pkg::KIND_START)) |=>
            ((run_left_reg == bstf_pkg::RUN_TWO) && (prev_data_reg == '0)))
        else $error("start command handled wrongly");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for byte_stuffing_tx_framer_core: command beats in, line bytes out.
// A scoreboard class predicts the framed byte stream and checks every output beat.
// Depends on bstf_pkg and the framer RTL only.

class framer_scoreboard;

    typedef struct packed {
        bstf_pkg::byte_t line;
        logic            last;
    } line_beat_t;

    bstf_pkg::byte_t start_tok;
    bstf_pkg::byte_t stop_tok;
    bstf_pkg::byte_t skip_tok;
    bstf_pkg::byte_t nop_val;
    bstf_pkg::byte_t last_data;
    line_beat_t      expected_line[$];
    int              mismatches;
    int              commands;
    int              bytes_checked;
    int              escapes;

    function new();
        start_tok     = bstf_pkg::START_TOKEN_RESET;
        stop_tok      = bstf_pkg::STOP_TOKEN_RESET;
        skip_tok      = bstf_pkg::SKIP_TOKEN_RESET;
        nop_val       = bstf_pkg::NOP_BYTE_RESET;
        last_data     = '0;
        mismatches    = 0;
        commands      = 0;
        bytes_checked = 0;
        escapes       = 0;
    endfunction

    function void set_register(bstf_pkg::cfg_index_t idx, bstf_pkg::byte_t value);
        case (idx)
            bstf_pkg::CFG_START_TOKEN: start_tok = value;
            bstf_pkg::CFG_STOP_TOKEN:  stop_tok  = value;
            bstf_pkg::CFG_SKIP_TOKEN:  skip_tok  = value;
            bstf_pkg::CFG_NOP_BYTE:    nop_val   = value;
            default:                   ;
        endcase
    endfunction

    function void note_command(bstf_pkg::kind_t k, bstf_pkg::byte_t d);
        bstf_pkg::byte_t run[$];
        case (k)
            bstf_pkg::KIND_START:
            begin
                run.push_back(start_tok);
                run.push_back(start_tok);
                last_data = '0;
            end
            bstf_pkg::KIND_DATA:
            begin
                if (d == skip_tok || (last_data == stop_tok && d == stop_tok))
                begin
                    run.push_back(skip_tok);
                    escapes++;
                end
                run.push_back(d);
                last_data = d;
            end
            bstf_pkg::KIND_STOP:
            begin
                run.push_back(nop_val);
                run.push_back(stop_tok);
                run.push_back(stop_tok);
            end
            default: return;
        endcase
        commands++;
        foreach (run[i])
            expected_line.push_back(line_beat_t'{run[i], (i == run.size() - 1)});
    endfunction

    function void check_line(bstf_pkg::byte_t b, logic re);
        line_beat_t exp_beat;
        bytes_checked++;
        if (expected_line.size() == 0)
        begin
            $error("line byte %02h arrived with no byte expected", b);
            mismatches++;
            return;
        end
        exp_beat = expected_line.pop_front();
        if (b !== exp_beat.line)
        begin
            $error("line_byte mismatch: expected %02h, actual %02h", exp_beat.line, b);
            mismatches++;
        end
        if (re !== exp_beat.last)
        begin
            $error("run_end mismatch: expected %0b, actual %0b", exp_beat.last, re);
            mismatches++;
        end
    endfunction

endclass

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bstf_pkg::kind_t KIND_UNUSED  = 2'd3;
    localparam int              STALL_LIMIT  = 1000;
    localparam int              LONG_HOLD    = 64;
    localparam int              DRAIN_CYCLES = 6;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    bstf_pkg::kind_t      kind      = bstf_pkg::KIND_START;
    bstf_pkg::byte_t      data_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    bstf_pkg::byte_t      line_byte;
    logic                 run_end;
    logic                 cfg_write = 1'b0;
    bstf_pkg::cfg_index_t cfg_index = bstf_pkg::CFG_START_TOKEN;
    bstf_pkg::byte_t      cfg_data  = '0;

    framer_scoreboard sb;
    bit  calm         = 1'b0;
    bit  hold_request = 1'b0;
    int  idle_cycles  = 0;
    int  settings     = 1;

    byte_stuffing_tx_framer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .line_byte (line_byte),
        .run_end   (run_end),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    function automatic bstf_pkg::byte_t pick_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return sb.stop_tok;
        if (r < 40)
            return sb.skip_tok;
        if (r < 45)
            return sb.start_tok;
        if (r < 50)
            return sb.nop_val;
        return bstf_pkg::byte_t'($urandom_range(0, 255));
    endfunction

    function automatic bstf_pkg::byte_t pick_token();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 8'h00;
        if (r < 4)
            return 8'hFF;
        return bstf_pkg::byte_t'($urandom_range(0, 255));
    endfunction

    task automatic push_command(bstf_pkg::kind_t k, bstf_pkg::byte_t d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        data_byte <= d;
        do @(posedge clk); while (!in_ready);
        sb.note_command(k, d);
    endtask

    task automatic write_reg(bstf_pkg::cfg_index_t idx, bstf_pkg::byte_t value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic configure(bstf_pkg::byte_t s, bstf_pkg::byte_t p, bstf_pkg::byte_t k,
                             bstf_pkg::byte_t n);
        write_reg(bstf_pkg::CFG_START_TOKEN, s);
        write_reg(bstf_pkg::CFG_STOP_TOKEN, p);
        write_reg(bstf_pkg::CFG_SKIP_TOKEN, k);
        write_reg(bstf_pkg::CFG_NOP_BYTE, n);
        cfg_write <= 1'b0;
        settings++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_line.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_message();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
        push_command(bstf_pkg::KIND_START, bstf_pkg::byte_t'($urandom_range(0, 255)));
        repeat (len) push_command(bstf_pkg::KIND_DATA, pick_data());
        push_command(bstf_pkg::KIND_STOP, bstf_pkg::byte_t'($urandom_range(0, 255)));
    endtask

    // Receiver side: random back-pressure, plus one long hold on request.
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_line(line_byte, run_end);
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("[byte_stuffing_tx_framer_core] ERROR");
        $finish;
    end

    initial
    begin
        int phase;
        int target;
        bstf_pkg::byte_t tok;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_command(bstf_pkg::KIND_START, 8'h00);
        push_command(bstf_pkg::KIND_DATA, 8'h00);
        push_command(bstf_pkg::KIND_DATA, 8'hFF);
        push_command(bstf_pkg::KIND_DATA, bstf_pkg::SKIP_TOKEN_RESET);
        push_command(bstf_pkg::KIND_DATA, bstf_pkg::STOP_TOKEN_RESET);
        push_command(bstf_pkg::KIND_DATA, bstf_pkg::STOP_TOKEN_RESET);
        push_command(bstf_pkg::KIND_DATA, bstf_pkg::STOP_TOKEN_RESET);
        push_command(bstf_pkg::KIND_STOP, 8'h00);
        push_command(KIND_UNUSED, 8'hFF);
        push_command(bstf_pkg::KIND_DATA, bstf_pkg::STOP_TOKEN_RESET);
        push_command(bstf_pkg::KIND_START, 8'hFF);
        push_command(bstf_pkg::KIND_DATA, bstf_pkg::STOP_TOKEN_RESET);
        push_command(bstf_pkg::KIND_DATA, bstf_pkg::START_TOKEN_RESET);
        push_command(bstf_pkg::KIND_DATA, bstf_pkg::NOP_BYTE_RESET);
        push_command(bstf_pkg::KIND_STOP, 8'hFF);
        drain();

        configure(8'h00, 8'h00, 8'hFF, 8'h00);
        push_command(bstf_pkg::KIND_START, 8'h00);
        push_command(bstf_pkg::KIND_DATA, 8'h00);
        push_command(bstf_pkg::KIND_DATA, 8'h00);
        push_command(bstf_pkg::KIND_DATA, 8'hFF);
        push_command(bstf_pkg::KIND_DATA, 8'h01);
        push_command(bstf_pkg::KIND_STOP, 8'h00);
        drain();

        configure(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_command(bstf_pkg::KIND_START, 8'h00);
        push_command(bstf_pkg::KIND_DATA, 8'hFF);
        push_command(bstf_pkg::KIND_DATA, 8'hFE);
        push_command(bstf_pkg::KIND_STOP, 8'h00);
        drain();

        for (phase = 0; phase < 5; phase++)
        begin
            tok = pick_token();
            configure(pick_token(), tok, ($urandom_range(0, 3) == 0) ? tok : pick_token(),
                      pick_token());
            calm = (phase == 1 || phase == 3);
            if (phase == 3)
                hold_request = 1'b1;
            target = sb.commands + 35;
            while (sb.commands < target)
            begin
                if ($urandom_range(0, 9) < 8)
                    send_message();
                else
                    push_command(bstf_pkg::kind_t'($urandom_range(0, 3)), pick_data());
            end
            drain();
        end

        $display("Sent %0d commands under %0d token settings;", sb.commands, settings);
        $display("checked %0d line bytes, %0d of them escaped.", sb.bytes_checked, sb.escapes);
        if (sb.mismatches == 0 && sb.expected_line.size() == 0)
            $display("[byte_stuffing_tx_framer_core] OK");
        else
            $display("[byte_stuffing_tx_framer_core] ERROR");
        $finish;
    end

endmodule

// File: byte_stuffing_tx_framer_core.f
src/bstf_pkg.sv
src/byte_stuffing_tx_framer_core.sv
sim/testbench.sv
